### hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### hdl/spc_pkg.sv
`default_nettype none
package spc_pkg;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned FracS = 30;
  // |dot| of an 18-bit normal with a 33-bit difference, summed over three axes
  localparam int unsigned DivW = 52;

  typedef enum logic [2:0] {
    REG_NX = 3'd0, REG_NY = 3'd1, REG_NZ = 3'd2,
    REG_PX = 3'd3, REG_PY = 3'd4, REG_PZ = 3'd5, REG_EPS = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_CULLED = 2'd0, ST_HIDDEN = 2'd1, ST_VISIBLE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [17:0] nx, ny, nz;
    logic signed [31:0] px, py, pz;
    logic [15:0]        eps;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]          status;
    logic                do_lerp;   // intersection to be computed
    logic                swap;      // start reported from Q
    logic [DivW-1:0]     num;       // numerator, 0..den when do_lerp is set
    logic [DivW-1:0]     den;
    logic signed [31:0]  px, py, pz, qx, qy, qz;
  } item_t;
endpackage
`default_nettype wire

### hdl/spc_front.sv
`default_nettype none
`include "assert_macros.svh"
module spc_front
  import spc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic signed [31:0] p_x_i, p_y_i, p_z_i, q_x_i, q_y_i, q_z_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output item_t                  item_o
);
  typedef enum logic [1:0] {
    SIDE_ON = 2'd0, SIDE_BACK = 2'd1, SIDE_FRONT = 2'd2
  } side_e;

  // stage 1: products; stage 2: sums and classification
  logic v1_q, v2_q;
  logic signed [51:0] mp_q [3];
  logic signed [51:0] mq_q [3];
  logic signed [31:0] p1_q [3];
  logic signed [31:0] q1_q [3];
  logic [31:0] thr1_q;
  item_t it_q;

  logic adv;
  assign adv = !v2_q || ready_i;
  assign stall_o = !adv;
  assign valid_o = v2_q;
  assign item_o = it_q;

  logic signed [31:0] pin [3];
  logic signed [31:0] qin [3];
  logic signed [31:0] pl [3];
  logic signed [17:0] nn [3];
  always_comb begin
    pin[0] = p_x_i; pin[1] = p_y_i; pin[2] = p_z_i;
    qin[0] = q_x_i; qin[1] = q_y_i; qin[2] = q_z_i;
    pl[0] = cfg_i.px; pl[1] = cfg_i.py; pl[2] = cfg_i.pz;
    nn[0] = cfg_i.nx; nn[1] = cfg_i.ny; nn[2] = cfg_i.nz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      for (int i = 0; i < 3; i++) begin
        mp_q[i] <= 52'(nn[i] * (33'(pin[i]) - 33'(pl[i])));
        mq_q[i] <= 52'(nn[i] * (33'(qin[i]) - 33'(pl[i])));
        p1_q[i] <= pin[i];
        q1_q[i] <= qin[i];
      end
      thr1_q <= {cfg_i.eps, 16'd0};
    end
  end

  logic signed [53:0] dp, dq, dd, num, den;
  logic [53:0] adp, adq, add;
  side_e cp, cq;
  item_t it_d;
  always_comb begin
    dp = 54'(mp_q[0]) + 54'(mp_q[1]) + 54'(mp_q[2]);
    dq = 54'(mq_q[0]) + 54'(mq_q[1]) + 54'(mq_q[2]);
    dd = dq - dp;
    adp = dp[53] ? 54'(-dp) : 54'(dp);
    adq = dq[53] ? 54'(-dq) : 54'(dq);
    add = dd[53] ? 54'(-dd) : 54'(dd);
    if (adp < 54'(thr1_q)) cp = SIDE_ON;
    else if (dp[53]) cp = SIDE_BACK;
    else cp = SIDE_FRONT;
    if (adq < 54'(thr1_q)) cq = SIDE_ON;
    else if (dq[53]) cq = SIDE_BACK;
    else cq = SIDE_FRONT;
    num = dd[53] ? dp : -dp;
    den = dd[53] ? -dd : dd;
    it_d = '0;
    it_d.px = p1_q[0]; it_d.py = p1_q[1]; it_d.pz = p1_q[2];
    it_d.qx = q1_q[0]; it_d.qy = q1_q[1]; it_d.qz = q1_q[2];
    it_d.num = num[DivW-1:0];
    it_d.den = den[DivW-1:0];
    if (cp == SIDE_BACK && cq == SIDE_BACK) it_d.status = ST_CULLED;
    else if ((cp == SIDE_ON && cq == SIDE_BACK) || (cp == SIDE_BACK && cq == SIDE_ON))
      it_d.status = ST_HIDDEN;
    else begin
      it_d.status = ST_VISIBLE;
      if (!((cp == SIDE_ON && cq == SIDE_FRONT) || (cp == SIDE_FRONT && cq == SIDE_ON))) begin
        it_d.swap = (cp == SIDE_BACK);
        it_d.do_lerp = (dd != 0) && (add >= 54'(thr1_q)) && !num[53] && (num <= den);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) it_q <= it_d;
  end

  `ASSERT_IMPL(a_hold, clk_i, rst_ni, (v2_q && !ready_i) |=> v2_q)
endmodule
`default_nettype wire

### hdl/spc_fifo.sv
`default_nettype none
`include "assert_macros.svh"
module spc_fifo
  import spc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t data_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output item_t      data_o
);
  item_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic push, pop;
  assign ready_o = (cnt_q != 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;
  assign data_o = mem_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
  `ASSERT_NEVER(a_ovf, clk_i, rst_ni, cnt_q > 3'd4)
endmodule
`default_nettype wire

### hdl/spc_back.sv
`default_nettype none
`include "assert_macros.svh"
module spc_back
  import spc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  output logic       valid_o,
  input  wire logic  stall_i,
  output logic [1:0] status_o,
  output logic signed [31:0] cpx_o, cpy_o, cpz_o, cqx_o, cqy_o, cqz_o
);
  localparam int unsigned Steps = FracS + 1; // 31 quotient bits
  localparam int unsigned Depth = Steps + 2;

  // restoring division, one quotient bit per stage
  logic          v_q   [Depth];
  item_t         it_q  [Depth];
  logic [DivW:0] rem_q [Steps];
  logic [30:0]   quo_q [Steps];
  logic adv;
  assign adv = !v_q[Depth-1] || !stall_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < Depth; i++) v_q[i] <= v_q[i-1];
    end
  end

  logic [DivW:0] r0;
  assign r0 = {1'b0, item_i.num};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[0] <= item_i;
      if (r0 >= {1'b0, item_i.den}) begin
        rem_q[0] <= r0 - {1'b0, item_i.den}; quo_q[0] <= 31'd1;
      end else begin
        rem_q[0] <= r0; quo_q[0] <= 31'd0;
      end
      for (int i = 1; i < Steps; i++) begin
        it_q[i] <= it_q[i-1];
        if ({rem_q[i-1][DivW-1:0], 1'b0} >= {1'b0, it_q[i-1].den}) begin
          rem_q[i] <= {rem_q[i-1][DivW-1:0], 1'b0} - {1'b0, it_q[i-1].den};
          quo_q[i] <= {quo_q[i-1][29:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i-1][DivW-1:0], 1'b0};
          quo_q[i] <= {quo_q[i-1][29:0], 1'b0};
        end
      end
    end
  end

  // lerp: multiply, round, add and saturate
  logic signed [32:0] u [3];
  logic signed [31:0] pp [3];
  logic signed [31:0] qq [3];
  item_t ia;
  assign ia = it_q[Steps-1];
  always_comb begin
    pp[0] = ia.px; pp[1] = ia.py; pp[2] = ia.pz;
    qq[0] = ia.qx; qq[1] = ia.qy; qq[2] = ia.qz;
    for (int i = 0; i < 3; i++) u[i] = 33'(qq[i]) - 33'(pp[i]);
  end
  logic [63:0] mag_q [3];
  logic        neg_q [3];
  logic signed [32:0] off [3];
  logic signed [34:0] r [3];
  logic signed [31:0] ce_q [3];
  logic signed [31:0] cs_q [3];
  logic signed [31:0] cb [3];
  item_t ib;
  assign ib = it_q[Steps];
  always_comb begin
    cb[0] = ib.px; cb[1] = ib.py; cb[2] = ib.pz;
    for (int i = 0; i < 3; i++) begin
      off[i] = 33'((mag_q[i] + 64'd536870912) >> FracS);
      r[i] = neg_q[i] ? 35'(cb[i]) - 35'(off[i]) : 35'(cb[i]) + 35'(off[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[Steps] <= ia;
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= 64'(u[i][32] ? 33'(-u[i]) : u[i]) * 64'(quo_q[Steps-1]);
        neg_q[i] <= u[i][32];
      end
      it_q[Steps+1] <= ib;
      for (int i = 0; i < 3; i++) begin
        if (ib.do_lerp) begin
          if (r[i] > 35'sd2147483647) ce_q[i] <= 32'sh7fffffff;
          else if (r[i] < -35'sd2147483648) ce_q[i] <= 32'sh80000000;
          else ce_q[i] <= r[i][31:0];
        end else begin
          ce_q[i] <= (i == 0) ? ib.qx : (i == 1) ? ib.qy : ib.qz;
        end
        cs_q[i] <= ib.swap ? ((i == 0) ? ib.qx : (i == 1) ? ib.qy : ib.qz) : cb[i];
      end
    end
  end

  logic vis;
  assign vis = (it_q[Depth-1].status == ST_VISIBLE);
  assign valid_o = v_q[Depth-1];
  assign status_o = it_q[Depth-1].status;
  assign cpx_o = vis ? cs_q[0] : '0;
  assign cpy_o = vis ? cs_q[1] : '0;
  assign cpz_o = vis ? cs_q[2] : '0;
  assign cqx_o = vis ? ce_q[0] : '0;
  assign cqy_o = vis ? ce_q[1] : '0;
  assign cqz_o = vis ? ce_q[2] : '0;

  `ASSERT_NEVER(a_bad_status, clk_i, rst_ni, valid_o && status_o == 2'd3)
endmodule
`default_nettype wire

### hdl/segment_plane_clipper.sv
// Segment clipper against one plane. Takes one segment a cycle while
// stall_o is low. A segment passes two front stages, one in the queue,
// 31 stages of the restoring divider for the intersection parameter and
// two for the interpolation. A classifying front end and the
// divide/interpolate back end are parted by a four-word queue.
// Registers are written over APB at byte address 4*index.
`default_nettype none
`include "assert_macros.svh"
module segment_plane_clipper
  import spc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic psel, penable, pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic valid_i,
  output logic stall_o,
  input  wire logic signed [31:0] p_x_i, p_y_i, p_z_i, q_x_i, q_y_i, q_z_i,
  output logic valid_o,
  input  wire logic stall_i,
  output logic [1:0] status_o,
  output logic signed [31:0] clip_p_x_o, clip_p_y_o, clip_p_z_o,
  output logic signed [31:0] clip_q_x_o, clip_q_y_o, clip_q_z_o
);
  cfg_t cfg_q;
  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{nx: 18'sd0, ny: 18'sd0, nz: 18'sd65536, px: '0, py: '0, pz: '0,
                 eps: 16'd7};
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(idx))
        REG_NX: cfg_q.nx <= pwdata[17:0];
        REG_NY: cfg_q.ny <= pwdata[17:0];
        REG_NZ: cfg_q.nz <= pwdata[17:0];
        REG_PX: cfg_q.px <= pwdata;
        REG_PY: cfg_q.py <= pwdata;
        REG_PZ: cfg_q.pz <= pwdata;
        REG_EPS: cfg_q.eps <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx_e'(idx))
      REG_NX: prdata = 32'(cfg_q.nx);
      REG_NY: prdata = 32'(cfg_q.ny);
      REG_NZ: prdata = 32'(cfg_q.nz);
      REG_PX: prdata = cfg_q.px;
      REG_PY: prdata = cfg_q.py;
      REG_PZ: prdata = cfg_q.pz;
      REG_EPS: prdata = {16'd0, cfg_q.eps};
      default: prdata = '0;
    endcase
  end

  logic f_v, f_r, q_v, q_r;
  item_t f_it, q_it;
  spc_front u_front (.clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i, .stall_o,
    .p_x_i, .p_y_i, .p_z_i, .q_x_i, .q_y_i, .q_z_i,
    .valid_o(f_v), .ready_i(f_r), .item_o(f_it));
  spc_fifo u_fifo (.clk_i, .rst_ni, .valid_i(f_v), .ready_o(f_r), .data_i(f_it),
    .valid_o(q_v), .ready_i(q_r), .data_o(q_it));
  spc_back u_back (.clk_i, .rst_ni, .valid_i(q_v), .ready_o(q_r), .item_i(q_it),
    .valid_o, .stall_i, .status_o,
    .cpx_o(clip_p_x_o), .cpy_o(clip_p_y_o), .cpz_o(clip_p_z_o),
    .cqx_o(clip_q_x_o), .cqy_o(clip_q_y_o), .cqz_o(clip_q_z_o));

  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, (valid_o && stall_i) |=> valid_o)
  `ASSERT_IMPL(a_pready, clk_i, rst_ni, psel |-> pready)
  `ASSERT_NEVER(a_status, clk_i, rst_ni, valid_o && status_o != ST_VISIBLE && clip_p_x_o != 0)
endmodule
`default_nettype wire
